// File: design/hv3_pkg.sv
// ----------------------------------------------------------------------------
// hv3_pkg
// Shared types and constants of the 3-pass HAVAL hash engine.
// ----------------------------------------------------------------------------
package hv3_pkg;

	localparam int unsigned QueueDepthDefault = 2;

	localparam logic [2:0] CodeMax = 3'd4;

	// one classified input item on its way from front to back
	typedef struct packed {
		logic [31:0] word;     // raw message word
		logic [31:0] pw;       // word with the 0x01 pad byte already placed
		logic        last;     // final word of the message
		logic        full;     // all four bytes count
		logic        tight;    // pad byte falls in byte 0 or 1
		logic [2:0]  nbytes;   // bytes taken, 0..4
		logic [2:0]  code;     // digest size code, 0..4
	} hv3_item_t;

	localparam logic [31:0] IV [8] = '{
		32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
		32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89
	};

	localparam logic [31:0] KC0 [32] = '{
		32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
		32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917,
		32'h9216D5D9, 32'h8979FB1B, 32'hD1310BA6, 32'h98DFB5AC,
		32'h2FFD72DB, 32'hD01ADFB7, 32'hB8E1AFED, 32'h6A267E96,
		32'hBA7C9045, 32'hF12C7F99, 32'h24A19947, 32'hB3916CF7,
		32'h0801F2E2, 32'h858EFC16, 32'h636920D8, 32'h71574E69,
		32'hA458FEA3, 32'hF4933D7E, 32'h0D95748F, 32'h728EB658,
		32'h718BCD58, 32'h82154AEE, 32'h7B54A41D, 32'hC25A59B5
	};

	localparam logic [31:0] KC1 [32] = '{
		32'h9C30D539, 32'h2AF26013, 32'hC5D1B023, 32'h286085F0,
		32'hCA417918, 32'hB8DB38EF, 32'h8E79DCB0, 32'h603A180E,
		32'h6C9E0E8B, 32'hB01E8A3E, 32'hD71577C1, 32'hBD314B27,
		32'h78AF2FDA, 32'h55605C60, 32'hE65525F3, 32'hAA55AB94,
		32'h57489862, 32'h63E81440, 32'h55CA396A, 32'h2AAB10B6,
		32'hB4CC5C34, 32'h1141E8CE, 32'hA15486AF, 32'h7C72E993,
		32'hB3EE1411, 32'h636FBC2A, 32'h2BA9C55D, 32'h741831F6,
		32'hCE5C3E16, 32'h9B87931E, 32'hAFD6BA33, 32'h6C24CF5C
	};

	localparam logic [4:0] ORD0 [32] = '{
		5'd5, 5'd14, 5'd26, 5'd18, 5'd11, 5'd28, 5'd7, 5'd16,
		5'd0, 5'd23, 5'd20, 5'd22, 5'd1, 5'd10, 5'd4, 5'd8,
		5'd30, 5'd3, 5'd21, 5'd9, 5'd17, 5'd24, 5'd29, 5'd6,
		5'd19, 5'd12, 5'd15, 5'd13, 5'd2, 5'd25, 5'd31, 5'd27
	};

	localparam logic [4:0] ORD1 [32] = '{
		5'd19, 5'd9, 5'd4, 5'd20, 5'd28, 5'd17, 5'd8, 5'd22,
		5'd29, 5'd14, 5'd25, 5'd12, 5'd24, 5'd30, 5'd16, 5'd26,
		5'd31, 5'd15, 5'd7, 5'd3, 5'd1, 5'd0, 5'd18, 5'd27,
		5'd13, 5'd6, 5'd21, 5'd10, 5'd23, 5'd11, 5'd5, 5'd2
	};

endpackage

// File: design/hv3_front.sv
// ----------------------------------------------------------------------------
// hv3_front
// Holds the digest size register and classifies each incoming item.
// ----------------------------------------------------------------------------
module hv3_front import hv3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic [31:0] word,
	input  logic [2:0]  valid_bytes,
	input  logic        last,
	output hv3_item_t   item
);

	logic [2:0] code_q;
	logic [2:0] nb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= CodeMax;
		end else if (cfg_we) begin
			code_q <= cfg_wdata;
		end
	end

	// non-final words always take four bytes; clip counts above four
	assign nb = (!last || valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

	always_comb begin
		item.word   = word;
		item.last   = last;
		item.nbytes = nb;
		item.full   = (nb == 3'd4);
		item.tight  = (nb == 3'd4) || (nb <= 3'd1);
		item.code   = (code_q > CodeMax) ? CodeMax : code_q;
		for (int b = 0; b < 4; b++) begin
			if (nb == 3'd4) begin
				item.pw[8*b +: 8] = (b == 0) ? 8'h01 : 8'h00;
			end else if (3'(b) < nb) begin
				item.pw[8*b +: 8] = word[8*b +: 8];
			end else if (3'(b) == nb) begin
				item.pw[8*b +: 8] = 8'h01;
			end else begin
				item.pw[8*b +: 8] = 8'h00;
			end
		end
	end

endmodule

// File: design/hv3_queue.sv
// ----------------------------------------------------------------------------
// hv3_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module hv3_queue import hv3_pkg::*; #(
	parameter int unsigned DEPTH = QueueDepthDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  hv3_item_t push_item,
	output logic      ready,
	input  logic      pop,
	output logic      avail,
	output hv3_item_t head
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	hv3_item_t         slot_q [DEPTH];
	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     rp_q;
	logic [CW-1:0]     cnt_q;

	assign ready = (cnt_q != CW'(DEPTH));
	assign avail = (cnt_q != '0);
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && ready) begin
			slot_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && ready) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop && avail) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			unique case ({push && ready, pop && avail})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: design/hv3_back.sv
// ----------------------------------------------------------------------------
// hv3_back
// Block buffer, padding sequencer, 96-step compression and digest output.
// ----------------------------------------------------------------------------
module hv3_back import hv3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        avail,
	input  hv3_item_t   head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_word,
	output logic        out_last
);

	typedef enum logic [3:0] {
		S_IDLE, S_PAD, S_ZERO, S_HALF, S_LO, S_HI,
		S_CPRIME, S_CSTEP, S_CADD, S_EMIT
	} state_t;

	state_t      state_q, ret_q, after;
	hv3_item_t   cur_q;
	logic [31:0] blk_mem [32];
	logic [31:0] rd_q;
	logic [4:0]  pos_q;
	logic [60:0] total_q;
	logic [31:0] chain_q [8];
	logic [31:0] t_q [8];
	logic [6:0]  step_q;
	logic [2:0]  k_q;
	logic        oval_q;
	logic [31:0] oword_q;
	logic        olast_q;

	logic        wr_en;
	logic [31:0] wr_data;
	logic [31:0] half;
	logic [6:0]  rd_idx;
	logic [4:0]  rd_addr;
	logic [31:0] f;
	logic [31:0] kc;
	logic [31:0] nw;
	logic        emit_last;
	logic [31:0] fold_word;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] fold_term(input logic [2:0] code, input logic [2:0] k,
		input logic [31:0] h4, input logic [31:0] h5, input logic [31:0] h6,
		input logic [31:0] h7);
		logic [31:0] r;
		r = '0;
		unique case (code)
			3'd0: begin
				unique case (k)
					3'd0: r = rotr((h7 & 32'h000000FF) | (h6 & 32'hFF000000)
						| (h5 & 32'h00FF0000) | (h4 & 32'h0000FF00), 8);
					3'd1: r = rotr((h7 & 32'h0000FF00) | (h6 & 32'h000000FF)
						| (h5 & 32'hFF000000) | (h4 & 32'h00FF0000), 16);
					3'd2: r = rotr((h7 & 32'h00FF0000) | (h6 & 32'h0000FF00)
						| (h5 & 32'h000000FF) | (h4 & 32'hFF000000), 24);
					3'd3: r = (h7 & 32'hFF000000) | (h6 & 32'h00FF0000)
						| (h5 & 32'h0000FF00) | (h4 & 32'h000000FF);
					default: r = '0;
				endcase
			end
			3'd1: begin
				unique case (k)
					3'd0: r = rotr((h7 & 32'h0000003F) | (h6 & 32'hFE000000)
						| (h5 & 32'h01F80000), 19);
					3'd1: r = rotr((h7 & 32'h00000FC0) | (h6 & 32'h0000003F)
						| (h5 & 32'hFE000000), 25);
					3'd2: r = (h7 & 32'h0007F000) | (h6 & 32'h00000FC0)
						| (h5 & 32'h0000003F);
					3'd3: r = ((h7 & 32'h01F80000) | (h6 & 32'h0007F000)
						| (h5 & 32'h00000FC0)) >> 6;
					3'd4: r = ((h7 & 32'hFE000000) | (h6 & 32'h01F80000)
						| (h5 & 32'h0007F000)) >> 12;
					default: r = '0;
				endcase
			end
			3'd2: begin
				unique case (k)
					3'd0: r = rotr((h7 & 32'h0000001F) | (h6 & 32'hFC000000), 26);
					3'd1: r = (h7 & 32'h000003E0) | (h6 & 32'h0000001F);
					3'd2: r = ((h7 & 32'h0000FC00) | (h6 & 32'h000003E0)) >> 5;
					3'd3: r = ((h7 & 32'h001F0000) | (h6 & 32'h0000FC00)) >> 10;
					3'd4: r = ((h7 & 32'h03E00000) | (h6 & 32'h001F0000)) >> 16;
					3'd5: r = ((h7 & 32'hFC000000) | (h6 & 32'h03E00000)) >> 21;
					default: r = '0;
				endcase
			end
			3'd3: begin
				unique case (k)
					3'd0: r = (h7 >> 27) & 32'h1F;
					3'd1: r = (h7 >> 22) & 32'h1F;
					3'd2: r = (h7 >> 18) & 32'h0F;
					3'd3: r = (h7 >> 13) & 32'h1F;
					3'd4: r = (h7 >> 9) & 32'h0F;
					3'd5: r = (h7 >> 4) & 32'h1F;
					3'd6: r = h7 & 32'h0F;
					default: r = '0;
				endcase
			end
			default: r = '0;
		endcase
		fold_term = r;
	endfunction

	assign pop       = (state_q == S_IDLE) && avail;
	assign out_valid = oval_q;
	assign out_word  = oword_q;
	assign out_last  = olast_q;

	// VERSION=1 | PASS=3<<3 | FPTLEN<<6 in the upper halfword
	assign half = {16'd25 | ((16'(cur_q.code) + 16'd4) << 11), 16'h0000};

	// buffer writes of the item and padding sequence
	always_comb begin
		wr_en   = 1'b0;
		wr_data = '0;
		after   = S_IDLE;
		unique case (state_q)
			S_IDLE: begin
				wr_en   = avail && (!head.last || head.full);
				wr_data = head.word;
				after   = head.last ? S_PAD : S_IDLE;
			end
			S_PAD: begin
				wr_en = 1'b1;
				if (cur_q.tight && pos_q == 5'd29) begin
					wr_data = cur_q.pw | half;
					after   = S_LO;
				end else begin
					wr_data = cur_q.pw;
					after   = S_ZERO;
				end
			end
			S_ZERO: begin
				wr_en = (pos_q != 5'd29);
				after = S_ZERO;
			end
			S_HALF: begin
				wr_en   = 1'b1;
				wr_data = half;
				after   = S_LO;
			end
			S_LO: begin
				wr_en   = 1'b1;
				wr_data = {total_q[28:0], 3'b000};
				after   = S_HI;
			end
			S_HI: begin
				wr_en   = 1'b1;
				wr_data = total_q[60:29];
				after   = S_EMIT;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// message word schedule, fetched one step ahead
	always_comb begin
		rd_idx = (state_q == S_CPRIME) ? 7'd0 : step_q + 7'd1;
		unique case (rd_idx[6:5])
			2'd1:    rd_addr = ORD0[rd_idx[4:0]];
			2'd2:    rd_addr = ORD1[rd_idx[4:0]];
			default: rd_addr = rd_idx[4:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			blk_mem[pos_q] <= wr_data;
		end
		rd_q <= blk_mem[rd_addr];
	end

	// one compression step; t_q holds the words already rotated into place
	always_comb begin
		unique case (step_q[6:5])
			2'd0: begin
				f  = (t_q[2] & (t_q[4] ^ t_q[3])) ^ (t_q[6] & t_q[0])
					^ (t_q[5] & t_q[1]) ^ t_q[4];
				kc = '0;
			end
			2'd1: begin
				f  = (t_q[5] & ((t_q[3] & ~t_q[0]) ^ (t_q[1] & t_q[2]) ^ t_q[4] ^ t_q[6]))
					^ (t_q[1] & (t_q[3] ^ t_q[2])) ^ (t_q[0] & t_q[2]) ^ t_q[6];
				kc = KC0[step_q[4:0]];
			end
			default: begin
				f  = (t_q[3] & ((t_q[5] & t_q[4]) ^ t_q[6] ^ t_q[0]))
					^ (t_q[5] & t_q[2]) ^ (t_q[4] & t_q[1]) ^ t_q[0];
				kc = KC1[step_q[4:0]];
			end
		endcase
		nw = rotr(f, 7) + rotr(t_q[7], 11) + rd_q + kc;
	end

	assign emit_last = (k_q == 3'd3 + cur_q.code);
	assign fold_word = chain_q[k_q]
		+ fold_term(cur_q.code, k_q, chain_q[4], chain_q[5], chain_q[6], chain_q[7]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			cur_q   <= '0;
			pos_q   <= '0;
			total_q <= '0;
			step_q  <= '0;
			k_q     <= '0;
			oval_q  <= 1'b0;
			oword_q <= '0;
			olast_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= IV[i];
				t_q[i]     <= '0;
			end
		end else begin
			if (oval_q && out_ready) begin
				oval_q <= 1'b0;
			end
			if (pop) begin
				cur_q   <= head;
				total_q <= total_q + 61'(head.nbytes);
				if (head.last && !head.full) begin
					state_q <= S_PAD;
				end
			end
			if (wr_en) begin
				pos_q <= pos_q + 5'd1;
				if (pos_q == 5'd31) begin
					state_q <= S_CPRIME;
					ret_q   <= after;
				end else begin
					state_q <= after;
				end
			end
			unique case (state_q)
				S_ZERO: begin
					if (pos_q == 5'd29) begin
						state_q <= S_HALF;
					end
				end
				S_CPRIME: begin
					for (int i = 0; i < 8; i++) begin
						t_q[i] <= chain_q[i];
					end
					step_q  <= '0;
					state_q <= S_CSTEP;
				end
				S_CSTEP: begin
					t_q[0] <= nw;
					for (int i = 1; i < 8; i++) begin
						t_q[i] <= t_q[i-1];
					end
					step_q <= step_q + 7'd1;
					if (step_q == 7'd95) begin
						state_q <= S_CADD;
					end
				end
				S_CADD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + t_q[i];
					end
					state_q <= ret_q;
				end
				S_EMIT: begin
					if (!oval_q || out_ready) begin
						oval_q  <= 1'b1;
						oword_q <= fold_word;
						olast_q <= emit_last;
						if (emit_last) begin
							k_q     <= '0;
							pos_q   <= '0;
							total_q <= '0;
							state_q <= S_IDLE;
							for (int i = 0; i < 8; i++) begin
								chain_q[i] <= IV[i];
							end
						end else begin
							k_q <= k_q + 3'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: design/haval3_hash_engine.sv
// ----------------------------------------------------------------------------
// haval3_hash_engine
// 3-pass HAVAL hash over a stream of little-endian 32-bit message words.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one message word per item; tlast marks the final word,
//   whose byte count (tdata[34:32]) may be 0..4. m_axis returns the digest
//   words H0 first, tlast on the last one (4 + size code words).
//   cfg_we/cfg_wdata write the digest size code (0..4 -> 128..256 bits,
//   higher codes act as 256); write it only while the engine is idle.
// Timing:
//   A non-final word is written to the buffer as it is popped; when it closes
//   a 32-word block, a compression follows (a read-ahead state, 96 steps at
//   one step per cycle through the single round unit, one feed-forward add).
//   A final word writes the padding into the buffer word by word, pausing
//   while a full block compresses (up to 35 writes, one or two compressions),
//   and then emits one digest word per cycle while m_axis_tready stays high.
//   A two-entry queue lets the front take words while the back compresses.
// Reset:
//   arst_n clears the queue, loads the initial chaining words and sets the
//   size code to 256 bits. The block buffer is not cleared.
// Stall:
//   If m_axis_tready is low the digest word holds and the back end waits;
//   the queue fills and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module haval3_hash_engine import hv3_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [31:0] message_word, [34:32] valid_bytes, rest 0
	input  logic        s_axis_tlast,   // final_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic        m_axis_tlast    // digest_last
);

	hv3_item_t item;
	hv3_item_t head;
	logic      q_avail;
	logic      q_pop;

	// classify the incoming word and sample the size code
	hv3_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.word        (s_axis_tdata[31:0]),
		.valid_bytes (s_axis_tdata[34:32]),
		.last        (s_axis_tlast),
		.item        (item)
	);

	// decouple intake from compression
	hv3_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_axis_tvalid),
		.push_item (item),
		.ready     (s_axis_tready),
		.pop       (q_pop),
		.avail     (q_avail),
		.head      (head)
	);

	// buffer, pad, compress, fold and emit
	hv3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (q_avail),
		.head      (head),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// File: design/hv3_checker.sv
// ----------------------------------------------------------------------------
// hv3_checker
// Port-level checks of the hash engine's digest output.
// ----------------------------------------------------------------------------
module hv3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// stalled digest word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("digest word changed while stalled");

	// digest words go out back to back until the last one
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside digest burst");

	// nothing follows the last digest word at once
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("output valid right after last digest word");

	// no output while in reset
	a_rst: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind haval3_hash_engine hv3_checker u_hv3_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
